// ===== rtl/dmacrb_pkg.sv =====
// Shared types and constants of the DMA controller register bank.
package dmacrb_pkg;

  localparam int unsigned NumChan   = 4;
  localparam int unsigned ChanW     = 2;
  localparam int unsigned RegIdxW   = 4;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 16;

  // Request opcodes; the fourth code is unused and does nothing
  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_ADVANCE = 2'd2
  } op_e;

  // Register indexes inside the sixteen-register window
  localparam logic [RegIdxW-1:0] REG_LAST_WORD = 4'd7;
  localparam logic [RegIdxW-1:0] REG_COMMAND   = 4'd8;
  localparam logic [RegIdxW-1:0] REG_REQUEST   = 4'd9;
  localparam logic [RegIdxW-1:0] REG_SGL_MASK  = 4'd10;
  localparam logic [RegIdxW-1:0] REG_MODE      = 4'd11;
  localparam logic [RegIdxW-1:0] REG_CLR_BPTR  = 4'd12;
  localparam logic [RegIdxW-1:0] REG_MSTR_CLR  = 4'd13;
  localparam logic [RegIdxW-1:0] REG_CLR_MASK  = 4'd14;
  localparam logic [RegIdxW-1:0] REG_ALL_MASK  = 4'd15;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PORT_BASE   = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_PORT_STRIDE = 8'd1;

  localparam logic [7:0] BYTE_NONE = 8'hFF;

  // Port decode result
  typedef struct packed {
    logic               hit;
    logic [RegIdxW-1:0] reg_idx;
  } decode_t;

  // One request as held in the input register
  typedef struct packed {
    logic [1:0]       opcode;
    logic [15:0]      port;
    logic [7:0]       write_data;
    logic [ChanW-1:0] channel;
  } req_t;

endpackage

// ===== rtl/dmacrb_if.sv =====
// Request, response and configuration channel interfaces.
interface dmacrb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] port;
  logic [7:0]  write_data;
  logic [1:0]  channel;

  modport source (output valid, opcode, port, write_data, channel, input ready);
  modport sink   (input valid, opcode, port, write_data, channel, output ready);
endinterface

interface dmacrb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       port_hit;
  logic       terminal_count;

  modport source (output valid, read_data, port_hit, terminal_count, input ready);
  modport sink   (input valid, read_data, port_hit, terminal_count, output ready);
endinterface

interface dmacrb_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/dmacrb_decode.sv =====
// Port window decode: hit flag and register index from port, base and stride.
module dmacrb_decode (
  input  logic [15:0]          port_i,
  input  logic [15:0]          base_i,
  input  logic [1:0]           stride_i,
  output dmacrb_pkg::decode_t  dec_o
);
  import dmacrb_pkg::*;

  logic [16:0] off;
  logic        wide;
  logic        in_span;

  // Offset from base; bit 16 flags a port below the base
  assign off  = {1'b0, port_i} - {1'b0, base_i};
  // Stride codes 2 and 3 space registers two ports apart
  assign wide = stride_i[1];

  always_comb begin
    in_span = wide ? (off[15:5] == '0) : (off[15:4] == '0);
    dec_o.hit     = !off[16] && in_span;
    dec_o.reg_idx = wide ? off[4:1] : off[3:0];
  end

endmodule

// ===== rtl/dma_controller_register_bank.sv =====
// Top level of the four-channel DMA controller register bank.
//
//   channel | direction | handshake     | payload
//   --------+-----------+---------------+-----------------------------------------
//   req_i   | in        | valid / ready | opcode, port, write_data, channel
//   rsp_o   | out       | valid / ready | read_data, port_hit, terminal_count
//   cfg_i   | in        | valid / ready | index (0 port_base, 1 port_stride), data
//
// A request is registered on accept, decoded and applied to the register state when the
// input register moves forward, and its response is registered at that same edge; one
// request per cycle is sustained while responses are taken. The response register is the
// only stall point; while it is held, a filled input register holds and state does not
// change. Reset clears all channel state, sets port_base 0 and port_stride 1; cfg_i is
// always ready.
module dma_controller_register_bank (
  input  logic          clk_i,
  input  logic          rst_ni,
  dmacrb_req_if.sink    req_i,
  dmacrb_rsp_if.source  rsp_o,
  dmacrb_cfg_if.sink    cfg_i
);
  import dmacrb_pkg::*;

  // Configuration
  logic [15:0] port_base_q;
  logic [1:0]  port_stride_q;

  // Input stage
  logic        in_valid_q;
  req_t        in_q;
  logic        advance;

  // Register state
  logic [15:0] chan_address_q [NumChan];
  logic [15:0] chan_address_d [NumChan];
  logic [15:0] chan_count_q   [NumChan];
  logic [15:0] chan_count_d   [NumChan];
  logic [7:0]  chan_mode_q    [NumChan];
  logic [7:0]  chan_mode_d    [NumChan];
  logic [NumChan-1:0] chan_masked_q, chan_masked_d;
  logic [7:0]  command_q, command_d;
  logic [7:0]  request_q, request_d;
  logic        byte_ptr_q, byte_ptr_d;

  // Output stage
  logic        out_valid_q;
  logic [7:0]  rd_q, rd_d;
  logic        hit_q, hit_d;
  logic        tc_q, tc_d;

  decode_t     dec;
  logic [15:0] word;
  logic [ChanW-1:0] wch;

  // Move the input stage forward when the response register is free or drains
  assign advance     = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_base_q   <= '0;
      port_stride_q <= 2'd1;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_PORT_BASE) begin
        port_base_q <= cfg_i.data;
      end else if (cfg_i.index == CFG_PORT_STRIDE) begin
        port_stride_q <= cfg_i.data[1:0];
      end
    end
  end

  // Capture accepted requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.opcode     <= req_i.opcode;
      in_q.port       <= req_i.port;
      in_q.write_data <= req_i.write_data;
      in_q.channel    <= req_i.channel;
    end
  end

  dmacrb_decode u_decode (
    .port_i   (in_q.port),
    .base_i   (port_base_q),
    .stride_i (port_stride_q),
    .dec_o    (dec)
  );

  // Selected address or count word of a word register access
  assign wch  = dec.reg_idx[2:1];
  assign word = dec.reg_idx[0] ? chan_count_q[wch] : chan_address_q[wch];

  // Apply one request to the register state and form its response
  always_comb begin
    chan_address_d = chan_address_q;
    chan_count_d   = chan_count_q;
    chan_mode_d    = chan_mode_q;
    chan_masked_d  = chan_masked_q;
    command_d      = command_q;
    request_d      = request_q;
    byte_ptr_d     = byte_ptr_q;
    rd_d           = BYTE_NONE;
    hit_d          = 1'b0;
    tc_d           = 1'b0;

    unique case (in_q.opcode)
      OP_READ: begin
        if (dec.hit) begin
          hit_d = 1'b1;
          if (dec.reg_idx <= REG_LAST_WORD) begin
            rd_d       = byte_ptr_q ? word[15:8] : word[7:0];
            byte_ptr_d = !byte_ptr_q;
          end else if (dec.reg_idx == REG_COMMAND) begin
            rd_d = command_q;
          end else if (dec.reg_idx == REG_ALL_MASK) begin
            rd_d = {{(8-NumChan){1'b0}}, chan_masked_q};
          end
        end
      end
      OP_WRITE: begin
        if (dec.hit) begin
          hit_d = 1'b1;
          if (dec.reg_idx <= REG_LAST_WORD) begin
            byte_ptr_d = !byte_ptr_q;
            if (dec.reg_idx[0]) begin
              if (byte_ptr_q) chan_count_d[wch][15:8] = in_q.write_data;
              else            chan_count_d[wch][7:0]  = in_q.write_data;
            end else begin
              if (byte_ptr_q) chan_address_d[wch][15:8] = in_q.write_data;
              else            chan_address_d[wch][7:0]  = in_q.write_data;
            end
          end else begin
            unique case (dec.reg_idx)
              REG_COMMAND:  command_d = in_q.write_data;
              REG_REQUEST:  request_d = in_q.write_data;
              REG_SGL_MASK: chan_masked_d[in_q.write_data[1:0]] = in_q.write_data[2];
              REG_MODE:     chan_mode_d[in_q.write_data[1:0]] = in_q.write_data;
              REG_CLR_BPTR: byte_ptr_d = 1'b0;
              REG_MSTR_CLR: begin
                for (int i = 0; i < NumChan; i++) begin
                  chan_address_d[i] = '0;
                  chan_count_d[i]   = '0;
                  chan_mode_d[i]    = '0;
                end
                chan_masked_d = '0;
                command_d     = '0;
                request_d     = '0;
                byte_ptr_d    = 1'b0;
              end
              REG_CLR_MASK: chan_masked_d = '0;
              REG_ALL_MASK: chan_masked_d = in_q.write_data[NumChan-1:0];
              default: ;
            endcase
          end
        end
      end
      OP_ADVANCE: begin
        tc_d = (chan_count_q[in_q.channel] == '0);
        chan_address_d[in_q.channel] = chan_address_q[in_q.channel] + 16'd1;
        chan_count_d[in_q.channel]   = chan_count_q[in_q.channel] - 16'd1;
      end
      default: ;
    endcase
  end

  // Commit state and response when the input stage moves forward
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChan; i++) begin
        chan_address_q[i] <= '0;
        chan_count_q[i]   <= '0;
        chan_mode_q[i]    <= '0;
      end
      chan_masked_q <= '0;
      command_q     <= '0;
      request_q     <= '0;
      byte_ptr_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        chan_address_q <= chan_address_d;
        chan_count_q   <= chan_count_d;
        chan_mode_q    <= chan_mode_d;
        chan_masked_q  <= chan_masked_d;
        command_q      <= command_d;
        request_q      <= request_d;
        byte_ptr_q     <= byte_ptr_d;
      end
    end
  end

  // Response payload register
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      rd_q  <= rd_d;
      hit_q <= hit_d;
      tc_q  <= tc_d;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.read_data      = rd_q;
  assign rsp_o.port_hit       = hit_q;
  assign rsp_o.terminal_count = tc_q;

endmodule

// ===== rtl/dmacrb_checker.sv =====
// Port-level checks of the DMA controller register bank, bound to the top level.
module dmacrb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [7:0] rsp_read_data_i,
  input logic       rsp_port_hit_i,
  input logic       rsp_terminal_count_i
);
  import dmacrb_pkg::*;

  // A held response keeps its valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response valid dropped while stalled");

  // A held response keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_read_data_i) && $stable(rsp_port_hit_i)
      && $stable(rsp_terminal_count_i))
    else $error("response payload changed while stalled");

  // Terminal count only comes from an advance, which never hits the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_terminal_count_i |-> !rsp_port_hit_i && rsp_read_data_i == BYTE_NONE)
    else $error("terminal count on a bus access");

  // Read data other than the idle byte needs a window hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_read_data_i != BYTE_NONE |-> rsp_port_hit_i)
    else $error("read data without window hit");

endmodule

bind dma_controller_register_bank dmacrb_checker u_dmacrb_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .rsp_valid_i          (rsp_o.valid),
  .rsp_ready_i          (rsp_o.ready),
  .rsp_read_data_i      (rsp_o.read_data),
  .rsp_port_hit_i       (rsp_o.port_hit),
  .rsp_terminal_count_i (rsp_o.terminal_count)
);

// ===== dv/dma_controller_register_bank_tb.sv =====
// Self-checking testbench for the DMA controller register bank: directed table, then random.
module dma_controller_register_bank_tb;
  import dmacrb_pkg::*;

  // Opcode left unused by the block
  localparam logic [1:0] OpUnused = 2'd3;

  // Word registers inside the window
  localparam logic [RegIdxW-1:0] REG_ADDR_CH0 = 4'd0;
  localparam logic [RegIdxW-1:0] REG_CNT_CH0  = 4'd1;

  localparam int unsigned RandItemsPerPhase = 125;
  localparam int unsigned NumPhases         = 6;
  localparam int unsigned IdleLimit         = 400;
  localparam int unsigned ReportLimit       = 10;

  typedef struct packed {
    logic [7:0] read_data;
    logic       port_hit;
    logic       terminal_count;
  } bus_rsp_t;

  typedef struct {
    req_t     item;
    bit       has_typed;
    bus_rsp_t typed_rsp;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dmacrb_req_if req_bus ();
  dmacrb_rsp_if rsp_bus ();
  dmacrb_cfg_if cfg_bus ();

  dma_controller_register_bank u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the register bank and its window setting
  logic [15:0] shadow_addr  [NumChan];
  logic [15:0] shadow_count [NumChan];
  logic [7:0]  shadow_mode  [NumChan];
  logic [3:0]  shadow_mask;
  logic [7:0]  shadow_cmd;
  logic [7:0]  shadow_req;
  logic        shadow_hi_byte;
  logic [15:0] win_base;
  logic [1:0]  win_stride;

  bus_rsp_t    due_rsp_q [$];
  stim_row_t   dir_tbl [$];
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  bit          tx_burst    = 1'b0;

  function automatic void clear_shadow();
    for (int i = 0; i < NumChan; i++) begin
      shadow_addr[i]  = '0;
      shadow_count[i] = '0;
      shadow_mode[i]  = '0;
    end
    shadow_mask    = '0;
    shadow_cmd     = '0;
    shadow_req     = '0;
    shadow_hi_byte = 1'b0;
  endfunction

  // Stride codes 0 and 1 space registers by one port, 2 and 3 by two
  function automatic int unsigned eff_stride();
    return win_stride[1] ? 2 : 1;
  endfunction

  function automatic logic [15:0] reg_port(input logic [RegIdxW-1:0] idx);
    return win_base + (win_stride[1] ? {11'd0, idx, 1'b0} : {12'd0, idx});
  endfunction

  // Apply one request to the shadow state and return the response it causes
  function automatic bus_rsp_t step_shadow(input req_t r);
    bus_rsp_t           rsp;
    logic [16:0]        off;
    logic [RegIdxW-1:0] idx;
    logic [ChanW-1:0]   ch;
    logic [15:0]        word;
    rsp = '{read_data: BYTE_NONE, port_hit: 1'b0, terminal_count: 1'b0};
    off = {1'b0, r.port} - {1'b0, win_base};
    if (r.opcode == OP_READ || r.opcode == OP_WRITE) begin
      // Window is not wrapped past the top of port space
      if (r.port >= win_base && off < 17'(16 * eff_stride())) begin
        rsp.port_hit = 1'b1;
        idx  = (eff_stride() == 2) ? off[4:1] : off[3:0];
        ch   = idx[2:1];
        word = idx[0] ? shadow_count[ch] : shadow_addr[ch];
        if (r.opcode == OP_READ) begin
          if (idx <= REG_LAST_WORD) begin
            rsp.read_data  = shadow_hi_byte ? word[15:8] : word[7:0];
            shadow_hi_byte = !shadow_hi_byte;
          end else if (idx == REG_COMMAND) begin
            rsp.read_data = shadow_cmd;
          end else if (idx == REG_ALL_MASK) begin
            rsp.read_data = {4'd0, shadow_mask};
          end
        end else if (idx <= REG_LAST_WORD) begin
          if (shadow_hi_byte) word[15:8] = r.write_data;
          else word[7:0] = r.write_data;
          if (idx[0]) shadow_count[ch] = word;
          else shadow_addr[ch] = word;
          shadow_hi_byte = !shadow_hi_byte;
        end else begin
          case (idx)
            REG_COMMAND:  shadow_cmd = r.write_data;
            REG_REQUEST:  shadow_req = r.write_data;
            REG_SGL_MASK: shadow_mask[r.write_data[1:0]] = r.write_data[2];
            REG_MODE:     shadow_mode[r.write_data[1:0]] = r.write_data;
            REG_CLR_BPTR: shadow_hi_byte = 1'b0;
            REG_MSTR_CLR: clear_shadow();
            REG_CLR_MASK: shadow_mask = '0;
            REG_ALL_MASK: shadow_mask = r.write_data[3:0];
            default: ;
          endcase
        end
      end
    end else if (r.opcode == OP_ADVANCE) begin
      rsp.terminal_count        = (shadow_count[r.channel] == 16'd0);
      shadow_addr[r.channel]    = shadow_addr[r.channel] + 16'd1;
      shadow_count[r.channel]   = shadow_count[r.channel] - 16'd1;
    end
    return rsp;
  endfunction

  // Draw a random request, mostly aimed at registers inside the current window
  function automatic req_t draw_req();
    req_t               r;
    int unsigned        pick;
    logic [RegIdxW-1:0] idx;
    logic [15:0]        span;
    pick = $urandom_range(0, 99);
    if (pick < 38) r.opcode = OP_READ;
    else if (pick < 76) r.opcode = OP_WRITE;
    else if (pick < 95) r.opcode = OP_ADVANCE;
    else r.opcode = OpUnused;
    span = 16'(16 * eff_stride());
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      if ($urandom_range(0, 9) < 6) begin
        idx = 4'($urandom_range(0, 7));
      end else begin
        idx = 4'($urandom_range(8, 15));
        // Keep master clear rare so that state can build up
        if (idx == REG_MSTR_CLR && $urandom_range(0, 7) != 0) idx = REG_ALL_MASK;
      end
      r.port = reg_port(idx) + 16'(win_stride[1] ? $urandom_range(0, 1) : 0);
    end else if (pick < 8) begin
      case ($urandom_range(0, 2))
        0:       r.port = win_base - 16'd1;
        1:       r.port = win_base + span - 16'd1;
        default: r.port = win_base + span;
      endcase
    end else begin
      r.port = 16'($urandom);
    end
    // Small bytes often, so that counts reach zero
    r.write_data = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom);
    r.channel    = 2'($urandom);
    return r;
  endfunction

  task automatic add_row(input logic [1:0] op, input logic [15:0] port,
                         input logic [7:0] data, input logic [1:0] ch,
                         input bit has_typed, input logic [7:0] rd,
                         input logic hit, input logic tc);
    stim_row_t row;
    row.item      = '{opcode: op, port: port, write_data: data, channel: ch};
    row.has_typed = has_typed;
    row.typed_rsp = '{read_data: rd, port_hit: hit, terminal_count: tc};
    dir_tbl.push_back(row);
  endtask

  // Offer one request after a random gap and hold it until accepted
  task automatic send_req(input req_t r, input bit has_typed, input bus_rsp_t typed_rsp);
    int unsigned gap;
    bus_rsp_t    due;
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.opcode     <= r.opcode;
    req_bus.port       <= r.port;
    req_bus.write_data <= r.write_data;
    req_bus.channel    <= r.channel;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    due = step_shadow(r);
    due_rsp_q.push_back(has_typed ? typed_rsp : due);
  endtask

  // Write port base then stride back to back
  task automatic set_window(input logic [15:0] base, input logic [1:0] stride);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= CFG_PORT_BASE;
    cfg_bus.data  <= base;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    win_base = base;
    cfg_bus.index <= CFG_PORT_STRIDE;
    cfg_bus.data  <= {14'd0, stride};
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    win_stride = stride;
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic drain_rsp();
    req_bus.valid <= 1'b0;
    while (due_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // Request side: reset, directed table, random phases, verdict
  initial begin : stimulus
    logic [15:0] phase_base   [NumPhases];
    logic [1:0]  phase_stride [NumPhases];
    req_bus.valid      <= 1'b0;
    req_bus.opcode     <= OP_READ;
    req_bus.port       <= '0;
    req_bus.write_data <= '0;
    req_bus.channel    <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= CFG_PORT_BASE;
    cfg_bus.data       <= '0;
    clear_shadow();
    win_base   = 16'h0000;
    win_stride = 2'd1;

    // Reset window: base 0, stride 1
    add_row(OP_READ,    reg_port(REG_ADDR_CH0), 8'h00, 2'd0, 1, 8'h00, 1, 0);
    add_row(OP_READ,    reg_port(REG_ADDR_CH0), 8'h00, 2'd0, 1, 8'h00, 1, 0);
    add_row(OP_READ,    reg_port(REG_COMMAND),  8'h00, 2'd0, 1, 8'h00, 1, 0);
    add_row(OP_READ,    reg_port(REG_ALL_MASK), 8'h00, 2'd0, 1, 8'h00, 1, 0);
    add_row(OP_READ,    reg_port(REG_REQUEST),  8'h00, 2'd0, 1, BYTE_NONE, 1, 0);
    add_row(OP_READ,    16'h0010,               8'h00, 2'd0, 1, BYTE_NONE, 0, 0);
    add_row(OP_READ,    16'hFFFF,               8'hFF, 2'd3, 1, BYTE_NONE, 0, 0);
    add_row(OP_ADVANCE, 16'h0000,               8'h00, 2'd0, 1, BYTE_NONE, 0, 1);
    add_row(OP_ADVANCE, 16'hFFFF,               8'hFF, 2'd3, 1, BYTE_NONE, 0, 1);
    add_row(OP_WRITE,   reg_port(REG_CNT_CH0),  8'hFF, 2'd0, 1, BYTE_NONE, 1, 0);
    add_row(OP_WRITE,   reg_port(REG_CNT_CH0),  8'h00, 2'd0, 1, BYTE_NONE, 1, 0);
    add_row(OP_ADVANCE, 16'h0000,               8'h00, 2'd0, 0, '0, 0, 0);
    add_row(OP_READ,    reg_port(REG_CNT_CH0),  8'h00, 2'd0, 0, '0, 0, 0);
    add_row(OP_WRITE,   reg_port(REG_CLR_BPTR), 8'h00, 2'd0, 1, BYTE_NONE, 1, 0);
    add_row(OP_READ,    reg_port(REG_CNT_CH0),  8'h00, 2'd0, 0, '0, 0, 0);
    add_row(OP_WRITE,   reg_port(REG_ALL_MASK), 8'hFF, 2'd0, 1, BYTE_NONE, 1, 0);
    add_row(OP_READ,    reg_port(REG_ALL_MASK), 8'h00, 2'd0, 0, '0, 0, 0);
    add_row(OP_WRITE,   reg_port(REG_SGL_MASK), 8'h02, 2'd0, 1, BYTE_NONE, 1, 0);
    add_row(OP_WRITE,   reg_port(REG_CLR_MASK), 8'h00, 2'd0, 1, BYTE_NONE, 1, 0);
    add_row(OP_WRITE,   reg_port(REG_SGL_MASK), 8'h07, 2'd0, 1, BYTE_NONE, 1, 0);
    add_row(OP_WRITE,   reg_port(REG_MODE),     8'hFF, 2'd0, 1, BYTE_NONE, 1, 0);
    add_row(OP_WRITE,   reg_port(REG_COMMAND),  8'hA5, 2'd0, 1, BYTE_NONE, 1, 0);
    add_row(OP_READ,    reg_port(REG_COMMAND),  8'h00, 2'd0, 0, '0, 0, 0);
    add_row(OP_WRITE,   reg_port(REG_REQUEST),  8'h80, 2'd0, 1, BYTE_NONE, 1, 0);
    add_row(OpUnused,   16'h0000,               8'hFF, 2'd3, 1, BYTE_NONE, 0, 0);
    add_row(OP_WRITE,   16'h8000,               8'h5A, 2'd0, 1, BYTE_NONE, 0, 0);
    add_row(OP_WRITE,   reg_port(REG_MSTR_CLR), 8'h00, 2'd0, 1, BYTE_NONE, 1, 0);
    add_row(OP_READ,    reg_port(REG_ALL_MASK), 8'h00, 2'd0, 1, 8'h00, 1, 0);
    add_row(OP_ADVANCE, 16'h0000,               8'h00, 2'd0, 1, BYTE_NONE, 0, 1);

    // Window settings: reset-like, stride code 2, top of port space with
    // stride code 3, single-port window with stride code 0, random, low base
    phase_base[0] = 16'h0000; phase_stride[0] = 2'd1;
    phase_base[1] = 16'h03F0; phase_stride[1] = 2'd2;
    phase_base[2] = 16'hFFF8; phase_stride[2] = 2'd3;
    phase_base[3] = 16'hFFFF; phase_stride[3] = 2'd0;
    phase_base[4] = 16'($urandom); phase_stride[4] = 2'd2;
    phase_base[5] = 16'h0080; phase_stride[5] = 2'd0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) send_req(dir_tbl[i].item, dir_tbl[i].has_typed, dir_tbl[i].typed_rsp);
    drain_rsp();

    for (int p = 0; p < NumPhases; p++) begin
      set_window(phase_base[p], phase_stride[p]);
      repeat (RandItemsPerPhase) send_req(draw_req(), 1'b0, '0);
      drain_rsp();
    end

    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Response side: stall at random, then compare with the oldest expectation
  initial begin : rsp_sink
    int unsigned stall;
    bit          rx_burst;
    bus_rsp_t    got;
    bus_rsp_t    want;
    rx_burst = 1'b0;
    rsp_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (rsp_bus.valid !== 1'b1) @(posedge clk_i);
      got = '{read_data: rsp_bus.read_data, port_hit: rsp_bus.port_hit,
              terminal_count: rsp_bus.terminal_count};
      if (due_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected response: read_data %02h port_hit %b terminal_count %b",
                   got.read_data, got.port_hit, got.terminal_count);
      end else begin
        want = due_rsp_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("response mismatch: read_data %02h/%02h port_hit %b/%b tc %b/%b (exp/act)",
                     want.read_data, got.read_data, want.port_hit, got.port_hit,
                     want.terminal_count, got.terminal_count);
        end
      end
    end
  end

  // Watchdog: end the run when no request, response or register write moves
  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
